// ===== sv/lkv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int WORD_W  = 32;
    localparam int CAP_RESET = (ENTRIES < 16) ? ENTRIES : 16;

    localparam logic [WORD_W-1:0] MINUS_ONE = '1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [CAP_W-1:0]  cap_t;

    typedef enum logic {
        ACT_GET = 1'b0,
        ACT_PUT = 1'b1
    } action_t;

    // Update decided for one request
    typedef struct packed {
        logic touch;      // slot becomes most recent
        logic fill;       // slot was free and becomes valid
        logic key_write;  // slot takes the new key
        logic val_write;  // slot takes the new value
        idx_t slot;
        idx_t rank;       // old rank of slot (promotion bound)
    } upd_t;

endpackage

// ===== sv/lkv_lookup.sv =====
// Parallel key match, fill and victim selection for one request.
module lkv_lookup (
    input  logic                   put,
    input  lkv_pkg::word_t         key,
    input  logic [lkv_pkg::ENTRIES-1:0] valid,
    input  lkv_pkg::idx_t          rank     [lkv_pkg::ENTRIES],
    input  lkv_pkg::word_t         keys     [lkv_pkg::ENTRIES],
    input  lkv_pkg::word_t         values   [lkv_pkg::ENTRIES],
    input  lkv_pkg::cnt_t          count,
    input  lkv_pkg::cap_t          cap,
    output lkv_pkg::upd_t          upd,
    output logic                   hit,
    output lkv_pkg::word_t         read_value
);
    import lkv_pkg::*;

    logic hit_any;
    idx_t hit_idx;
    idx_t free_idx;
    idx_t victim_idx;
    idx_t oldest_rank;
    logic has_room;

    // Valid entries hold ranks 0..count-1, so the oldest one has rank count-1
    assign oldest_rank = idx_t'(count - cnt_t'(1));
    assign has_room    = CMP_W'(count) < CMP_W'(cap);

    always_comb begin
        hit_any    = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (valid[i] && keys[i] == key) begin
                hit_any = 1'b1;
                hit_idx = idx_t'(i);
            end
            if (!valid[i]) begin
                free_idx = idx_t'(i);
            end
            if (valid[i] && rank[i] == oldest_rank) begin
                victim_idx = idx_t'(i);
            end
        end
    end

    always_comb begin
        upd = '0;
        if (hit_any) begin
            upd.touch     = 1'b1;
            upd.val_write = put;
            upd.slot      = hit_idx;
            upd.rank      = rank[hit_idx];
        end else if (put) begin
            upd.touch     = 1'b1;
            upd.key_write = 1'b1;
            upd.val_write = 1'b1;
            if (has_room) begin
                upd.fill = 1'b1;
                upd.slot = free_idx;
            end else begin
                upd.slot = victim_idx;
                upd.rank = oldest_rank;
            end
        end
    end

    assign hit        = hit_any;
    assign read_value = (hit_any && !put) ? values[hit_idx] : MINUS_ONE;

endmodule

// ===== sv/lkv_store.sv =====
// Entry storage: keys, values, valid bits, recency ranks and fill count.
module lkv_store (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   fire,
    input  lkv_pkg::upd_t          upd,
    input  lkv_pkg::word_t         key,
    input  lkv_pkg::word_t         value,
    output logic [lkv_pkg::ENTRIES-1:0] valid,
    output lkv_pkg::idx_t          rank     [lkv_pkg::ENTRIES],
    output lkv_pkg::word_t         keys     [lkv_pkg::ENTRIES],
    output lkv_pkg::word_t         values   [lkv_pkg::ENTRIES],
    output lkv_pkg::cnt_t          count
);
    import lkv_pkg::*;

    logic [ENTRIES-1:0] valid_reg;
    idx_t               rank_reg  [ENTRIES];
    word_t              key_reg   [ENTRIES];
    word_t              value_reg [ENTRIES];
    cnt_t               count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else if (fire && upd.touch) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (idx_t'(i) == upd.slot) begin
                    rank_reg[i] <= '0;
                end else if (valid_reg[i] && (upd.fill || rank_reg[i] < upd.rank)) begin
                    // on a fill age every valid entry, else every entry more recent than the promoted one
                    rank_reg[i] <= rank_reg[i] + idx_t'(1);
                end
            end
            if (upd.fill) begin
                valid_reg[upd.slot] <= 1'b1;
                count_reg           <= count_reg + cnt_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && upd.key_write) begin
            key_reg[upd.slot] <= key;
        end
        if (fire && upd.val_write) begin
            value_reg[upd.slot] <= value;
        end
    end

    assign valid  = valid_reg;
    assign rank   = rank_reg;
    assign keys   = key_reg;
    assign values = value_reg;
    assign count  = count_reg;

endmodule

// ===== sv/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
//
// Requests enter on the s_ channel: s_tuser is the action (get or put),
// s_tdata carries key and write value. Each request gives exactly one
// result word on the m_ channel: m_tuser is the hit flag, m_tdata the
// read value (stored value on a get hit, all ones otherwise).
// A request word is captured in an input register; once the result
// register is free or being taken, a single pass of parallel key
// compares, fill/victim selection and rank update runs against all
// entries, writes the store and loads the result register (m_tvalid).
// One request is taken every cycle while m_tready stays high; the rate
// is set by the single compare-and-update pass over the entry registers.
// cfg_valid/cfg_data write the capacity register; the user must write it
// only while the block is idle, which the block itself does not enforce;
// 0 is taken as 1 and values above the entry count as the entry count.
// Reset (aresetn low, synchronous) empties the cache, drops any word in
// flight and sets capacity to 16. When the receiver holds m_tready low the
// result register holds, the input register fills, and s_tready falls.
module lru_key_value_cache (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [63:0]             s_tdata,   // key [31:0], write_value [63:32]
    input  logic                    s_tuser,   // action
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,   // read_value [31:0]
    output logic                    m_tuser,   // hit
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0] cfg_data
);
    import lkv_pkg::*;

    logic    in_valid_reg;
    action_t in_action_reg;
    word_t   in_key_reg;
    word_t   in_value_reg;

    logic    out_valid_reg;
    logic    out_hit_reg;
    word_t   out_value_reg;

    cap_t    cap_reg;
    cap_t    cap_next;

    logic    proceed;

    logic [ENTRIES-1:0] valid;
    idx_t    rank   [ENTRIES];
    word_t   keys   [ENTRIES];
    word_t   values [ENTRIES];
    cnt_t    count;
    upd_t    upd;
    logic    hit;
    word_t   read_value;

    assign proceed  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proceed;
    assign cfg_ready = 1'b1;

    // clamp capacity to 1..ENTRIES
    always_comb begin
        cap_next = cfg_data;
        if (cfg_data == '0) begin
            cap_next = cap_t'(1);
        end else if (CMP_W'(cfg_data) > CMP_W'(ENTRIES)) begin
            cap_next = cap_t'(ENTRIES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= cap_t'(CAP_RESET);
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cap_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= action_t'(s_tuser);
            in_key_reg    <= s_tdata[31:0];
            in_value_reg  <= s_tdata[63:32];
        end
    end

    lkv_lookup u_lookup (
        .put        (in_action_reg == ACT_PUT),
        .key        (in_key_reg),
        .valid      (valid),
        .rank       (rank),
        .keys       (keys),
        .values     (values),
        .count      (count),
        .cap        (cap_reg),
        .upd        (upd),
        .hit        (hit),
        .read_value (read_value)
    );

    lkv_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (proceed),
        .upd     (upd),
        .key     (in_key_reg),
        .value   (in_value_reg),
        .valid   (valid),
        .rank    (rank),
        .keys    (keys),
        .values  (values),
        .count   (count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proceed) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed) begin
            out_hit_reg   <= hit;
            out_value_reg <= read_value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = out_value_reg;

endmodule

// ===== test/tb_lru_key_value_cache.sv =====
// Self-checking testbench for the LRU key-value cache: directed and random request streams.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
    import lkv_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLD_OFF       = 200;

    typedef struct packed {
        logic  hit;
        word_t read_value;
    } lookup_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // key [31:0], write_value [63:32]
    logic        s_tuser;   // action
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // read_value [31:0]
    logic        m_tuser;   // hit
    logic        cfg_valid;
    logic        cfg_ready;
    cap_t        cfg_data;

    // Shadow copy of the cache contents and LRU order
    word_t           tag_mem [ENTRIES];
    word_t           data_mem [ENTRIES];
    bit              live [ENTRIES];
    bit [IDX_W-1:0]  age [ENTRIES];
    cnt_t            fill_count = '0;
    cap_t            cap_limit = cap_t'(CAP_RESET);

    lookup_t pending_lookups [$];
    word_t   key_pool [$];
    int      error_count = 0;
    int      quiet_cycles = 0;
    int      rx_hold_cycles = 0;
    bit      tx_idle = 1'b1;
    bit      rx_idle = 1'b1;

    lru_key_value_cache uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Make entry s the most recent; every live entry newer than it ages by one.
    function automatic void make_newest(int s);
        bit [IDX_W-1:0] r;
        r = age[s];
        for (int i = 0; i < ENTRIES; i++) begin
            if (live[i] && i != s && age[i] < r)
                age[i] = age[i] + 1'b1;
        end
        age[s] = '0;
    endfunction

    function automatic lookup_t cache_access(action_t act, word_t key, word_t val);
        int      found;
        int      slot;
        int      victim;
        lookup_t res;
        found = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (live[i] && tag_mem[i] == key) begin
                found = i;
                break;
            end
        end
        res.hit        = (found >= 0);
        res.read_value = MINUS_ONE;
        if (act == ACT_GET) begin
            if (found >= 0) begin
                res.read_value = data_mem[found];
                make_newest(found);
            end
        end else if (found >= 0) begin
            data_mem[found] = val;
            make_newest(found);
        end else begin
            slot = -1;
            if (fill_count < cap_limit) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!live[i]) begin
                        slot = i;
                        break;
                    end
                end
            end
            if (slot >= 0) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (live[i])
                        age[i] = age[i] + 1'b1;
                end
                live[slot]     = 1'b1;
                age[slot]      = '0;
                tag_mem[slot]  = key;
                data_mem[slot] = val;
                fill_count     = fill_count + 1'b1;
            end else begin
                // replace the oldest live entry
                victim = -1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (live[i] && (victim < 0 || age[i] > age[victim]))
                        victim = i;
                end
                if (victim >= 0) begin
                    tag_mem[victim]  = key;
                    data_mem[victim] = val;
                    make_newest(victim);
                end
            end
        end
        return res;
    endfunction

    // Check results first, then predict the word accepted at this edge.
    always @(posedge aclk) begin
        lookup_t exp_res;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_lookups.size() == 0) begin
                    $error("result word with no request pending: hit=%0b read_value=%h",
                           m_tuser, m_tdata);
                    error_count++;
                end else begin
                    exp_res = pending_lookups.pop_front();
                    if (m_tuser !== exp_res.hit) begin
                        $error("hit: expected %0b, got %0b", exp_res.hit, m_tuser);
                        error_count++;
                    end
                    if (m_tdata !== exp_res.read_value) begin
                        $error("read_value: expected %h, got %h", exp_res.read_value, m_tdata);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_lookups.push_back(cache_access(action_t'(s_tuser), s_tdata[31:0],
                                                       s_tdata[63:32]));
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random gap before each word, plus an optional long hold-off.
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = rx_idle ? $urandom_range(0, 5) : 0;
            gap += rx_hold_cycles;
            rx_hold_cycles = 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    task automatic issue_request(action_t act, word_t key, word_t val);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {val, key};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Drop valid, drain all pending results, then let the pipeline settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_capacity(cap_t v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        if (v == 0)
            cap_limit = cap_t'(1);
        else if (v > ENTRIES)
            cap_limit = cap_t'(ENTRIES);
        else
            cap_limit = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic build_pool(int n);
        key_pool.delete();
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 7))
                0:       key_pool.push_back(32'h8000_0000);
                1:       key_pool.push_back(32'h7FFF_FFFF);
                2:       key_pool.push_back(32'h0000_0000);
                3:       key_pool.push_back(32'hFFFF_FFFF);
                default: key_pool.push_back($urandom);
            endcase
        end
    endtask

    function automatic word_t pick_key();
        if ($urandom_range(0, 9) < 8)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return $urandom;
    endfunction

    task automatic test_empty_misses();
        issue_request(ACT_GET, 32'h0000_0000, 32'h0000_0000);
        issue_request(ACT_GET, 32'hFFFF_FFFF, 32'h1234_5678);
    endtask

    task automatic test_extreme_puts();
        issue_request(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        issue_request(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        issue_request(ACT_PUT, 32'h0000_0000, 32'h0000_0000);
        issue_request(ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_request(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        issue_request(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        issue_request(ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        issue_request(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_update_present();
        issue_request(ACT_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
        issue_request(ACT_GET, 32'h0000_0000, 32'h5A5A_5A5A);
    endtask

    // Capacity below the fill count: new keys replace the oldest, nothing else evicts.
    task automatic test_shrink_capacity();
        set_capacity(cap_t'(0));
        issue_request(ACT_PUT, 32'h1357_9BDF, 32'h0000_0001);
        issue_request(ACT_GET, 32'h8000_0000, 32'h0000_0000);
        issue_request(ACT_GET, 32'h1357_9BDF, 32'h0000_0000);
        issue_request(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        issue_request(ACT_PUT, 32'h7FFF_FFFF, 32'h0000_0002);
    endtask

    task automatic test_capacity_clamp();
        set_capacity(cap_t'(31));
        issue_request(ACT_PUT, 32'h2468_ACE0, 32'hDEAD_BEEF);
        issue_request(ACT_GET, 32'h2468_ACE0, 32'h0000_0000);
        set_capacity(cap_t'(2));
        issue_request(ACT_PUT, 32'hCAFE_F00D, 32'h0BAD_CAFE);
    endtask

    task automatic test_random_phases();
        cap_t caps [9];
        caps = '{5'd16, 5'd1, 5'd3, 5'd8, 5'd16, 5'd0, 5'd31, 5'd0, 5'd2};
        caps[7] = cap_t'($urandom_range(1, ENTRIES));
        for (int p = 0; p < 9; p++) begin
            set_capacity(caps[p]);
            tx_idle = (p % 3 != 0);
            rx_idle = (p % 3 != 1);
            build_pool((caps[p] == 0 ? 1 : (caps[p] > ENTRIES ? ENTRIES : caps[p]))
                       + $urandom_range(0, 4));
            for (int n = 0; n < 150; n++)
                issue_request(action_t'($urandom_range(0, 1)), pick_key(), $urandom);
        end
    endtask

    // Hold the receiver off so the pipeline fills and s_tready drops.
    task automatic test_backpressure();
        set_capacity(cap_t'(4));
        build_pool(6);
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        rx_hold_cycles = HOLD_OFF;
        for (int n = 0; n < 60; n++)
            issue_request(action_t'($urandom_range(0, 1)), pick_key(), $urandom);
        tx_idle = 1'b1;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_misses();
        test_extreme_puts();
        test_update_present();
        test_shrink_capacity();
        test_capacity_clamp();
        test_random_phases();
        test_backpressure();
        wait_idle();

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lkv_pkg.sv
sv/lkv_lookup.sv
sv/lkv_store.sv
sv/lru_key_value_cache.sv
test/tb_lru_key_value_cache.sv
